// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define PTC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ptc assertion failed");

// clocked assertion that also holds during reset
`define PTC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ptc assertion failed");

`endif

// ----- design/ptc_pkg.sv -----
`timescale 1ns / 1ps

package ptc_pkg;

  // saturation limits of the effective configuration
  localparam int MaxCanvasDim = 4096;
  localparam int MaxBlockRes  = 64;

  localparam int CoordW  = 12;  // local and canvas coordinates
  localparam int SizeW   = 13;  // patch size and canvas dimensions
  localparam int ResW    = 7;   // block resolution
  localparam int OrgW    = 19;  // origin times resolution
  localparam int SpanW   = 20;  // size times resolution
  localparam int PosW    = 21;  // term plus origin
  localparam int IndexW  = 24;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOriginU   = 3'd0,
    CfgOriginV   = 3'd1,
    CfgSizeU     = 3'd2,
    CfgSizeV     = 3'd3,
    CfgOrient    = 3'd4,
    CfgBlockRes  = 3'd5,
    CfgCanvasW   = 3'd6,
    CfgCanvasH   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OrDefault = 4'd0,
    OrRot90   = 4'd1,
    OrRot180  = 4'd2,
    OrRot270  = 4'd3,
    OrMirror  = 4'd4,
    OrMRot90  = 4'd5,
    OrMRot180 = 4'd6,
    OrMRot270 = 4'd7,
    OrSwap    = 4'd8
  } orient_e;

  // effective configuration, resolution and canvas already saturated
  typedef struct packed {
    logic [CoordW-1:0] origin_u;
    logic [CoordW-1:0] origin_v;
    logic [SizeW-1:0]  size_u;
    logic [SizeW-1:0]  size_v;
    orient_e           orient;
    logic [ResW-1:0]   block_res;
    logic [SizeW-1:0]  canvas_w;
    logic [SizeW-1:0]  canvas_h;
  } cfg_t;

  // oriented terms before the origin is added
  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [SpanW-1:0] xt;
    logic [SpanW-1:0] yt;
    logic [OrgW-1:0]  ou;
    logic [OrgW-1:0]  ov;
  } term_t;

  // canvas position after bounds check
  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [SizeW-1:0] x;
    logic [SizeW-1:0] y;
  } place_t;

endpackage

// ----- design/ptc_cfg.sv -----
`timescale 1ns / 1ps

module ptc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [ptc_pkg::SizeW-1:0]      cfg_wdata_i,
  output ptc_pkg::cfg_t                  cfg_o
);

  localparam int ResW  = ptc_pkg::ResW;
  localparam int SizeW = ptc_pkg::SizeW;

  ptc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_u  <= '0;
      cfg_q.origin_v  <= '0;
      cfg_q.size_u    <= SizeW'(1);
      cfg_q.size_v    <= SizeW'(1);
      cfg_q.orient    <= ptc_pkg::OrDefault;
      cfg_q.block_res <= ResW'(1);
      cfg_q.canvas_w  <= SizeW'(4096);
      cfg_q.canvas_h  <= SizeW'(4096);
    end else if (cfg_we_i) begin
      case (ptc_pkg::cfg_idx_e'(cfg_addr_i))
        ptc_pkg::CfgOriginU:  cfg_q.origin_u  <= cfg_wdata_i[11:0];
        ptc_pkg::CfgOriginV:  cfg_q.origin_v  <= cfg_wdata_i[11:0];
        ptc_pkg::CfgSizeU:    cfg_q.size_u    <= cfg_wdata_i;
        ptc_pkg::CfgSizeV:    cfg_q.size_v    <= cfg_wdata_i;
        ptc_pkg::CfgOrient:   cfg_q.orient    <= ptc_pkg::orient_e'(cfg_wdata_i[3:0]);
        ptc_pkg::CfgBlockRes: cfg_q.block_res <= cfg_wdata_i[ResW-1:0];
        ptc_pkg::CfgCanvasW:  cfg_q.canvas_w  <= cfg_wdata_i;
        ptc_pkg::CfgCanvasH:  cfg_q.canvas_h  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturate resolution and canvas to their limits
  always_comb begin
    cfg_o = cfg_q;
    if (int'(cfg_q.block_res) > ptc_pkg::MaxBlockRes) begin
      cfg_o.block_res = ResW'(ptc_pkg::MaxBlockRes);
    end
    if (int'(cfg_q.canvas_w) > ptc_pkg::MaxCanvasDim) begin
      cfg_o.canvas_w = SizeW'(ptc_pkg::MaxCanvasDim);
    end
    if (int'(cfg_q.canvas_h) > ptc_pkg::MaxCanvasDim) begin
      cfg_o.canvas_h = SizeW'(ptc_pkg::MaxCanvasDim);
    end
  end

endmodule

// ----- design/ptc_orient.sv -----
`timescale 1ns / 1ps

module ptc_orient (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ptc_pkg::CoordW-1:0]   u_i,
  input  logic [ptc_pkg::CoordW-1:0]   v_i,
  input  ptc_pkg::cfg_t                cfg_i,
  output ptc_pkg::term_t               term_o
);

  localparam int CoordW = ptc_pkg::CoordW;
  localparam int OrgW   = ptc_pkg::OrgW;
  localparam int SpanW  = ptc_pkg::SpanW;

  // stage 1: scale origin and size by the block resolution
  logic                valid1_q;
  logic [CoordW-1:0]   u1_q, v1_q;
  logic [OrgW-1:0]     ou1_q, ov1_q;
  logic [SpanW-1:0]    su1_q, sv1_q;
  ptc_pkg::orient_e    orient1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q      <= u_i;
    v1_q      <= v_i;
    ou1_q     <= OrgW'(cfg_i.origin_u) * OrgW'(cfg_i.block_res);
    ov1_q     <= OrgW'(cfg_i.origin_v) * OrgW'(cfg_i.block_res);
    su1_q     <= SpanW'(cfg_i.size_u) * SpanW'(cfg_i.block_res);
    sv1_q     <= SpanW'(cfg_i.size_v) * SpanW'(cfg_i.block_res);
    orient1_q <= cfg_i.orient;
  end

  // stage 2: reflected terms and orientation select
  logic [SpanW-1:0] u_ext, v_ext, ru, rv;
  logic             ru_bad, rv_bad;
  ptc_pkg::term_t   term_d, term_q;

  always_comb begin
    u_ext  = SpanW'(u1_q);
    v_ext  = SpanW'(v1_q);
    ru_bad = u_ext >= su1_q;
    rv_bad = v_ext >= sv1_q;
    ru     = su1_q - SpanW'(1) - u_ext;
    rv     = sv1_q - SpanW'(1) - v_ext;

    term_d.valid = valid1_q;
    term_d.ou    = ou1_q;
    term_d.ov    = ov1_q;
    term_d.bad   = 1'b0;
    term_d.xt    = '0;
    term_d.yt    = '0;
    case (orient1_q)
      ptc_pkg::OrDefault: begin
        term_d.xt = u_ext;
        term_d.yt = v_ext;
      end
      ptc_pkg::OrRot90: begin
        term_d.xt  = rv;
        term_d.yt  = u_ext;
        term_d.bad = rv_bad;
      end
      ptc_pkg::OrRot180: begin
        term_d.xt  = ru;
        term_d.yt  = rv;
        term_d.bad = ru_bad | rv_bad;
      end
      ptc_pkg::OrRot270: begin
        term_d.xt  = v_ext;
        term_d.yt  = ru;
        term_d.bad = ru_bad;
      end
      ptc_pkg::OrMirror: begin
        term_d.xt  = ru;
        term_d.yt  = v_ext;
        term_d.bad = ru_bad;
      end
      ptc_pkg::OrMRot90: begin
        term_d.xt  = rv;
        term_d.yt  = ru;
        term_d.bad = ru_bad | rv_bad;
      end
      ptc_pkg::OrMRot180: begin
        term_d.xt  = u_ext;
        term_d.yt  = rv;
        term_d.bad = rv_bad;
      end
      ptc_pkg::OrMRot270, ptc_pkg::OrSwap: begin
        term_d.xt = v_ext;
        term_d.yt = u_ext;
      end
      default: begin
        term_d.bad = 1'b1;  // undefined orientation code
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= '0;
    end else begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

// ----- design/ptc_place.sv -----
`timescale 1ns / 1ps

module ptc_place (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptc_pkg::term_t   term_i,
  input  ptc_pkg::cfg_t    cfg_i,
  output ptc_pkg::place_t  place_o
);

  localparam int PosW  = ptc_pkg::PosW;
  localparam int SizeW = ptc_pkg::SizeW;

  logic [PosW-1:0]  x, y;
  ptc_pkg::place_t  place_q;

  // origin add, then bounds check against the canvas
  always_comb begin
    x = PosW'(term_i.xt) + PosW'(term_i.ou);
    y = PosW'(term_i.yt) + PosW'(term_i.ov);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      place_q <= '0;
    end else begin
      place_q.valid <= term_i.valid;
      place_q.bad   <= term_i.bad | (x >= PosW'(cfg_i.canvas_w)) |
                       (y >= PosW'(cfg_i.canvas_h));
      place_q.x     <= x[SizeW-1:0];
      place_q.y     <= y[SizeW-1:0];
    end
  end

  assign place_o = place_q;

endmodule

// ----- design/ptc_index.sv -----
`timescale 1ns / 1ps

module ptc_index (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptc_pkg::place_t              place_i,
  input  ptc_pkg::cfg_t                cfg_i,
  output logic                         done_o,
  output logic [ptc_pkg::CoordW-1:0]   canvas_x_o,
  output logic [ptc_pkg::CoordW-1:0]   canvas_y_o,
  output logic [ptc_pkg::IndexW-1:0]   canvas_index_o,
  output logic                         out_of_range_o
);

  localparam int CoordW = ptc_pkg::CoordW;
  localparam int SizeW  = ptc_pkg::SizeW;
  localparam int IndexW = ptc_pkg::IndexW;
  localparam int ProdW  = 2 * SizeW;

  // stage 4: row offset
  logic [ProdW-1:0]  prod;
  logic              valid4_q, bad4_q;
  logic [SizeW-1:0]  x4_q, y4_q;
  logic [IndexW-1:0] row4_q;

  assign prod = ProdW'(cfg_i.canvas_w) * ProdW'(place_i.y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
    end else begin
      valid4_q <= place_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    bad4_q <= place_i.bad;
    x4_q   <= place_i.x;
    y4_q   <= place_i.y;
    row4_q <= prod[IndexW-1:0];
  end

  // stage 5: index and output register, zeroed when out of range
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_of_range_o <= bad4_q;
    if (bad4_q) begin
      canvas_x_o     <= '0;
      canvas_y_o     <= '0;
      canvas_index_o <= '0;
    end else begin
      canvas_x_o     <= x4_q[CoordW-1:0];
      canvas_y_o     <= y4_q[CoordW-1:0];
      canvas_index_o <= row4_q + IndexW'(x4_q);
    end
  end

  assign done_o = done_q;

endmodule

// ----- design/patch_to_canvas_coordinate_map.sv -----
`timescale 1ns / 1ps

// patch-to-canvas coordinate map: takes a patch-local (u,v) request on start and
// returns the canvas column, row and linear index x + canvas_width * y with an
// out_of_range flag. one request is taken every clock (busy stays low) and its
// result is shown on done_o for one cycle, one result per request, in order,
// after passing the five register stages (resolution scaling, orientation select,
// origin add and bounds check, row multiply, index add). the receiver cannot
// stall, so results must be taken in the cycle they are shown. configuration
// writes are registered; write only while no request is in flight. out-of-range
// results carry zero coordinates and index. block resolution saturates at 64
// and canvas sizes at 4096.
module patch_to_canvas_coordinate_map (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic [ptc_pkg::CoordW-1:0]   local_u_i,
  input  logic [ptc_pkg::CoordW-1:0]   local_v_i,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [ptc_pkg::SizeW-1:0]    cfg_wdata_i,
  // result channel
  output logic                         done_o,
  output logic [ptc_pkg::CoordW-1:0]   canvas_x_o,
  output logic [ptc_pkg::CoordW-1:0]   canvas_y_o,
  output logic [ptc_pkg::IndexW-1:0]   canvas_index_o,
  output logic                         out_of_range_o
);

  ptc_pkg::cfg_t   cfg;
  ptc_pkg::term_t  term;
  ptc_pkg::place_t place;
  logic            accept;

  // fully pipelined, never holds off a request
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // register file with saturated effective values
  ptc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // stages 1 and 2: scale by resolution, reflect and select per orientation
  ptc_orient u_orient (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .u_i     (local_u_i),
    .v_i     (local_v_i),
    .cfg_i   (cfg),
    .term_o  (term)
  );

  // stage 3: add origin, check canvas bounds
  ptc_place u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .term_i  (term),
    .cfg_i   (cfg),
    .place_o (place)
  );

  // stages 4 and 5: linear index and result register
  ptc_index u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .place_i        (place),
    .cfg_i          (cfg),
    .done_o         (done_o),
    .canvas_x_o     (canvas_x_o),
    .canvas_y_o     (canvas_y_o),
    .canvas_index_o (canvas_index_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

// ----- design/ptc_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [ptc_pkg::CoordW-1:0]   canvas_x_o,
  input logic [ptc_pkg::CoordW-1:0]   canvas_y_o,
  input logic [ptc_pkg::IndexW-1:0]   canvas_index_o,
  input logic                         out_of_range_o
);

  logic fields_zero;

  assign fields_zero = (canvas_x_o == '0) && (canvas_y_o == '0) && (canvas_index_o == '0);

  // every accepted request yields a result on done_o
  `PTC_ASSERT(a_req_to_result, (start && !busy) |-> ##5 done_o)

  // no result without an earlier accepted request
  `PTC_ASSERT(a_result_has_req, done_o |-> $past(start && !busy, 5))

  // out-of-range results carry zero position and index
  `PTC_ASSERT(a_oor_zero, (done_o && out_of_range_o) |-> fields_zero)

  // a valid index never lies below its column
  `PTC_ASSERT_ALWAYS(a_index_ge_x, (done_o && !out_of_range_o) |-> (canvas_index_o >= {12'd0, canvas_x_o}))

endmodule

bind patch_to_canvas_coordinate_map ptc_checker u_ptc_checker (.*);
